/* hdl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the stack machine execute block
// Operation codes, decoded command, fault codes and channel payload structs.
// ----------------------------------------------------------------------------
package smx_pkg;

  // Default number of stack entries
  localparam int DefaultStackDepth = 256;

  // Entries in the queue between decode and execute
  localparam int QueueDepth = 2;

  // Builtin number that dumps the stack (no effect here)
  localparam logic [63:0] BuiltinDump = 64'd1;

  // Instruction operation codes
  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_HALT       = 4'd1,
    OP_PUSH_INT   = 4'd2,
    OP_ADD        = 4'd3,
    OP_BUILTIN    = 4'd4,
    OP_JUMP       = 4'd5,
    OP_DROP       = 4'd6,
    OP_DUP        = 4'd7,
    OP_SWAP       = 4'd8,
    OP_ROTATE     = 4'd9,
    OP_PUSH_LABEL = 4'd10
  } op_e;

  // Commands seen by the execute stage
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_HALT,
    CMD_PUSH,
    CMD_ADD,
    CMD_JUMP,
    CMD_DROP,
    CMD_DUP,
    CMD_SWAP,
    CMD_ROT,
    CMD_BAD
  } cmd_e;

  // Fault codes
  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_OVERFLOW  = 2'd1,
    FAULT_UNDERFLOW = 2'd2,
    FAULT_BADOP     = 2'd3
  } fault_e;

  // Input item
  typedef struct packed {
    logic [3:0]  operation;
    logic [63:0] operand;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [63:0] pc_after;
    logic [63:0] top_value;
    logic [8:0]  depth;
    logic        halted;
    logic [1:0]  fault;
  } out_item_t;

  // Classified instruction carried through the queue
  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  min_depth;  // entries the instruction needs on the stack
    logic        grows;      // instruction adds one entry
    logic [63:0] operand;
  } cmd_t;

  // Queue status toward the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/smx_decode.sv */
// ----------------------------------------------------------------------------
// smx_decode: instruction front end
// Accepts input transfers while the queue has room and classifies each
// operation into a command with its stack depth requirements.
// ----------------------------------------------------------------------------
module smx_decode import smx_pkg::*; (
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  input  q_status_t q_status_i,
  output logic      q_push_o,
  output cmd_t      q_cmd_o
);

  // Hold the input while the queue is full
  assign in_stall_o = q_status_i.full;
  assign q_push_o   = in_valid_i && !q_status_i.full;

  // Classify the operation
  always_comb begin
    q_cmd_o.cmd       = CMD_BAD;
    q_cmd_o.min_depth = 2'd0;
    q_cmd_o.grows     = 1'b0;
    q_cmd_o.operand   = in_i.operand;
    unique case (in_i.operation)
      OP_NOP:     q_cmd_o.cmd = CMD_NOP;
      OP_HALT:    q_cmd_o.cmd = CMD_HALT;
      OP_PUSH_INT, OP_PUSH_LABEL: begin
        q_cmd_o.cmd   = CMD_PUSH;
        q_cmd_o.grows = 1'b1;
      end
      OP_ADD: begin
        q_cmd_o.cmd       = CMD_ADD;
        q_cmd_o.min_depth = 2'd2;
      end
      OP_BUILTIN: begin
        // dump does nothing, every other builtin stops the machine
        q_cmd_o.cmd = (in_i.operand == BuiltinDump) ? CMD_NOP : CMD_HALT;
      end
      OP_JUMP: begin
        q_cmd_o.cmd       = CMD_JUMP;
        q_cmd_o.min_depth = 2'd1;
      end
      OP_DROP: begin
        q_cmd_o.cmd       = CMD_DROP;
        q_cmd_o.min_depth = 2'd1;
      end
      OP_DUP: begin
        q_cmd_o.cmd       = CMD_DUP;
        q_cmd_o.min_depth = 2'd1;
        q_cmd_o.grows     = 1'b1;
      end
      OP_SWAP: begin
        q_cmd_o.cmd       = CMD_SWAP;
        q_cmd_o.min_depth = 2'd2;
      end
      OP_ROTATE: begin
        q_cmd_o.cmd       = CMD_ROT;
        q_cmd_o.min_depth = 2'd3;
      end
      default:    q_cmd_o.cmd = CMD_BAD;
    endcase
  end

endmodule

/* hdl/smx_queue.sv */
// ----------------------------------------------------------------------------
// smx_queue: command queue between front end and execute stage
// Small circular buffer; the head entry is presented combinationally.
// ----------------------------------------------------------------------------
module smx_queue import smx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_cmd_i,
  input  logic      pop_i,
  output logic      head_valid_o,
  output cmd_t      head_cmd_o,
  output q_status_t status_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_valid_o   = !status_o.empty;
  assign head_cmd_o     = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the new entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hdl/smx_execute.sv */
// ----------------------------------------------------------------------------
// smx_execute: stack machine back end
// Executes one command per cycle unless stalled. The top three stack entries
// live in registers; deeper entries live in a memory whose read port always
// fetches the entry just below them, so a pop refills in the same cycle.
// ----------------------------------------------------------------------------
module smx_execute import smx_pkg::*; #(
  parameter int StackDepth = DefaultStackDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  localparam int DW = $clog2(StackDepth + 1);
  localparam int AW = $clog2(StackDepth);

  // Architectural state
  logic [63:0]   pc_q, pc_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          halted_q, halted_d;
  fault_e        fault_q, fault_d;
  logic [63:0]   t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;

  // Spill memory for entries below the top three
  logic [63:0]   mem_q [StackDepth];
  logic [63:0]   rd_data_q;
  logic          byp_q;
  logic [63:0]   byp_data_q;
  logic [63:0]   t3;
  logic          mem_we;
  logic [DW-1:0] wr_depth, rd_depth;
  logic [AW-1:0] mem_waddr, mem_raddr;

  // Output register
  logic          out_valid_q;
  out_item_t     out_q;
  logic          out_ready;
  logic          fire;
  logic          underflow, overflow;
  logic [DW+8:0] depth_ext;

  assign t3        = byp_q ? byp_data_q : rd_data_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign fire      = cmd_valid_i && out_ready;
  assign cmd_pop_o = fire;

  assign underflow = depth_q < DW'(cmd_i.min_depth);
  assign overflow  = cmd_i.grows && (depth_q == DW'(StackDepth));

  // Next machine state
  always_comb begin
    pc_d     = pc_q;
    depth_d  = depth_q;
    halted_d = halted_q;
    fault_d  = fault_q;
    t0_d     = t0_q;
    t1_d     = t1_q;
    t2_d     = t2_q;
    mem_we   = 1'b0;
    if (fire && !halted_q) begin
      priority if (underflow) begin
        fault_d  = FAULT_UNDERFLOW;
        halted_d = 1'b1;
      end else if (overflow) begin
        fault_d  = FAULT_OVERFLOW;
        halted_d = 1'b1;
      end else begin
        pc_d = pc_q + 64'd1;
        unique case (cmd_i.cmd)
          CMD_NOP: ;
          CMD_HALT: halted_d = 1'b1;
          CMD_PUSH, CMD_DUP: begin
            t0_d    = (cmd_i.cmd == CMD_PUSH) ? cmd_i.operand : t0_q;
            t1_d    = t0_q;
            t2_d    = t1_q;
            depth_d = depth_q + DW'(1);
            mem_we  = depth_q >= DW'(3);
          end
          CMD_ADD: begin
            t0_d    = t0_q + t1_q;
            t1_d    = t2_q;
            t2_d    = t3;
            depth_d = depth_q - DW'(1);
          end
          CMD_JUMP: begin
            pc_d    = t0_q;
            t0_d    = t1_q;
            t1_d    = t2_q;
            t2_d    = t3;
            depth_d = depth_q - DW'(1);
          end
          CMD_DROP: begin
            t0_d    = t1_q;
            t1_d    = t2_q;
            t2_d    = t3;
            depth_d = depth_q - DW'(1);
          end
          CMD_SWAP: begin
            t0_d = t1_q;
            t1_d = t0_q;
          end
          CMD_ROT: begin
            t0_d = t1_q;
            t1_d = t2_q;
            t2_d = t0_q;
          end
          CMD_BAD: begin
            pc_d     = pc_q;
            fault_d  = FAULT_BADOP;
            halted_d = 1'b1;
          end
          default: pc_d = pc_q;
        endcase
      end
    end
  end

  // Spill slot of the third entry, and the slot just below the new top three
  assign wr_depth  = depth_q - DW'(3);
  assign rd_depth  = depth_d - DW'(4);
  assign mem_waddr = wr_depth[AW-1:0];
  assign mem_raddr = rd_depth[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= t2_q;
    end
    rd_data_q  <= mem_q[mem_raddr];
    byp_data_q <= t2_q;
  end

  // Result seen after this command
  assign depth_ext = (DW + 9)'(depth_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      depth_q     <= '0;
      halted_q    <= 1'b0;
      fault_q     <= FAULT_NONE;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      depth_q  <= depth_d;
      halted_q <= halted_d;
      fault_q  <= fault_d;
      // forward a spill that lands on the slot being fetched
      byp_q    <= mem_we && (mem_waddr == mem_raddr);
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stack top registers and output payload
  always_ff @(posedge clk_i) begin
    t0_q <= t0_d;
    t1_q <= t1_d;
    t2_q <= t2_d;
    if (fire) begin
      out_q.pc_after  <= pc_d;
      out_q.top_value <= (depth_d != '0) ? t0_d : 64'd0;
      out_q.depth     <= depth_ext[8:0];
      out_q.halted    <= halted_d;
      out_q.fault     <= fault_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hdl/stack_machine_execute_top.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute_top: 64-bit value-stack machine execute block
// Runs one instruction per input transfer and returns the machine state.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+---------------------------
//   input   | in_valid_i | in_stall_o  | in_i  (operation, operand)
//   output  | out_valid_o| out_stall_i | out_o (pc, top, depth, ...)
//
// One instruction per cycle sustained unless the output stalls; a result is
// offered once its input transfer has been written into the command queue
// and then executed into the output register.
// The rate is set by the execute stage, which holds the top three stack
// entries in registers and refills from the spill memory's read port.
// Reset clears pc, depth, halt and fault; the spill memory is not cleared.
// Input stalls only when the two-entry command queue is full.
// ----------------------------------------------------------------------------
module stack_machine_execute_top import smx_pkg::*; #(
  parameter int StackDepth = DefaultStackDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  q_status_t q_status;
  logic      q_push;
  cmd_t      q_push_cmd;
  logic      q_pop;
  logic      head_valid;
  cmd_t      head_cmd;

  // Front end: accept and classify
  smx_decode u_decode (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  // Decouple front end and execute stage
  smx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (q_push_cmd),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .status_o     (q_status)
  );

  // Back end: execute against the stack
  smx_execute #(
    .StackDepth (StackDepth)
  ) u_execute (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // A reported fault always comes with the halt flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.fault == FAULT_NONE || out_o.halted))
    else $error("fault reported without halt");

  // A new result needs a queued command the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_status.empty))
    else $error("result appeared without a queued command");

  // An input transfer into an empty queue leaves it occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && q_status.empty) |=> !q_status.empty)
    else $error("accepted command lost in queue");

endmodule
